### hw/rtl/assert_macros.svh
// Assertion helpers; expect clk and rst_n in the calling scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/rbai_pkg.sv
`timescale 1ns / 1ps

package rbai_pkg;

    localparam int MAX_SAMPLES    = 256;
    localparam int HIST_DEPTH     = MAX_SAMPLES + 1;
    localparam int HIST_AW        = $clog2(HIST_DEPTH);
    localparam int FILL_W         = $clog2(HIST_DEPTH + 1);
    localparam int AGE_W          = $clog2(MAX_SAMPLES + 1);

    localparam int GATES_W        = 12;
    localparam int PERIOD_W       = 16;
    localparam int AZIM_W         = 16;
    localparam int CAUSE_W        = 3;

    localparam int N_W            = 9;
    localparam int RES_W          = 12;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 12;

    localparam int COUNT_W        = 13;
    localparam int COUNT_MAX      = (1 << COUNT_W) - 1;
    localparam int FULL_CIRCLE    = 36000;
    localparam int PERIOD_TOL_US  = 1000;
    localparam int TIMEOUT_SHIFT  = 4;
    localparam int TO_W           = AGE_W + TIMEOUT_SHIFT;

    // remainder unit: dividend 2*az + res, divisor 2*res
    localparam int NUM_W          = 18;
    localparam int DIV_W          = RES_W + 2;
    localparam int DCNT_W         = $clog2(NUM_W + 1);
    localparam int T_W            = NUM_W - 1;

    localparam int NCMP_W         = (AGE_W > N_W) ? AGE_W : N_W;
    localparam int PCMP_W         = (TO_W > COUNT_W) ? TO_W : COUNT_W;

    typedef logic [GATES_W-1:0]  gates_t;
    typedef logic [PERIOD_W-1:0] period_t;
    typedef logic [AZIM_W-1:0]   azim_t;

    typedef struct packed {
        gates_t  gates;
        period_t period;
        azim_t   azim;
    } hist_entry_t;

    typedef enum logic [CAUSE_W-1:0] {
        CAUSE_NONE    = 3'd0,
        CAUSE_CW      = 3'd1,
        CAUSE_CCW     = 3'd2,
        CAUSE_CW_WRAP = 3'd3,
        CAUSE_CCW_WRAP= 3'd4,
        CAUSE_TIMEOUT = 3'd5,
        CAUSE_COUNT   = 3'd6
    } cause_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BEAM_LEN  = 2'd0,
        CFG_DUAL_POL  = 2'd1,
        CFG_INDEX_AZ  = 2'd2,
        CFG_AZ_RES    = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_MID1,
        ST_MID2,
        ST_MIDCAP,
        ST_DIV,
        ST_TGT,
        ST_RESULT
    } state_t;

endpackage

### hw/rtl/rbai_pulse_if.sv
`timescale 1ns / 1ps

interface rbai_pulse_if import rbai_pkg::*; ();
    logic    valid;
    logic    ready;
    gates_t  pulse_gates;
    period_t pulse_period_us;
    azim_t   pulse_azimuth;

    modport source (
        output valid,
        output pulse_gates,
        output pulse_period_us,
        output pulse_azimuth,
        input  ready
    );

    modport sink (
        input  valid,
        input  pulse_gates,
        input  pulse_period_us,
        input  pulse_azimuth,
        output ready
    );
endinterface

### hw/rtl/rbai_beam_if.sv
`timescale 1ns / 1ps

interface rbai_beam_if import rbai_pkg::*; ();
    logic   valid;
    logic   ready;
    logic   beam_ready;
    azim_t  beam_azimuth;
    cause_t beam_cause;

    modport source (
        output valid,
        output beam_ready,
        output beam_azimuth,
        output beam_cause,
        input  ready
    );

    modport sink (
        input  valid,
        input  beam_ready,
        input  beam_azimuth,
        input  beam_cause,
        output ready
    );
endinterface

### hw/rtl/radar_beam_azimuth_indexer.sv
`timescale 1ns / 1ps

// Radar beam azimuth indexer: one pulse beat in, one beam beat out. Each pulse is
// written into a 257-entry history ring and then checked by a small sequencer that
// reads the history RAM one entry per cycle (ages 1 to N-1 for gate and period match,
// N being the configured pulses per beam, then the two middle pulses) and, with
// azimuth indexing on, runs an 18-step serial remainder to round the target azimuth.
// The sequencer goes to the result early when the history is not yet deep enough or
// the scan hits a mismatch; a result that finds the output register still full waits
// until it drains. pulse.ready is low from acceptance until the result is loaded. The
// result sits in an output register, so the next pulse is taken while a finished
// beam beat still waits downstream.

`include "assert_macros.svh"

module radar_beam_azimuth_indexer import rbai_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    rbai_pulse_if.sink            pulse,
    rbai_beam_if.source           beam,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // configuration
    logic [N_W-1:0]    n_cfg_reg;
    logic              dual_reg;
    logic              index_reg;
    logic [RES_W-1:0]  res_cfg_reg;

    // history
    hist_entry_t       mem [HIST_DEPTH];
    hist_entry_t       rd_data_reg;
    logic [HIST_AW-1:0] rd_addr;
    logic              wr_en;

    // control state
    state_t            state_reg, state_next;
    logic [HIST_AW-1:0] head_reg, head_next, head_inc;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [COUNT_W-1:0] psb_reg, psb_next;
    logic [AGE_W-1:0]  age_reg, age_next;
    logic              pend_reg, pend_next;
    logic              fail_reg, fail_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;

    // datapath
    gates_t            g0_reg, g0_next;
    period_t           p0_reg, p0_next;
    azim_t             m1_reg, m1_next;
    azim_t             m2_reg, m2_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [DIV_W-1:0]  rem_reg, rem_next;
    logic [T_W-1:0]    t_reg, t_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic              out_beam_reg, out_beam_next;
    azim_t             out_az_reg, out_az_next;
    cause_t            out_cause_reg, out_cause_next;

    // derived
    logic [AGE_W-1:0]  n_eff;
    logic [AGE_W-1:0]  half;
    logic [RES_W-1:0]  res_eff;
    logic [FILL_W-1:0] need;
    logic [AGE_W-1:0]  rd_age;
    logic [NUM_W-1:0]  numv;
    logic [DIV_W-1:0]  divisor;
    logic [DIV_W-1:0]  trial;
    logic              mismatch;
    period_t           pdiff;
    logic              load_out;
    cause_t            res_cause;
    azim_t             res_az;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_cfg_reg   <= N_W'(64);
            dual_reg    <= 1'b0;
            index_reg   <= 1'b1;
            res_cfg_reg <= RES_W'(100);
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_BEAM_LEN:  n_cfg_reg   <= cfg_wdata[N_W-1:0];
                CFG_DUAL_POL:  dual_reg    <= cfg_wdata[0];
                CFG_INDEX_AZ:  index_reg   <= cfg_wdata[0];
                CFG_AZ_RES:    res_cfg_reg <= cfg_wdata[RES_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        logic [NCMP_W-1:0] n_wide;
        n_wide = NCMP_W'(n_cfg_reg);
        if (n_wide < NCMP_W'(2))
            n_eff = AGE_W'(2);
        else if (n_wide > NCMP_W'(MAX_SAMPLES))
            n_eff = AGE_W'(MAX_SAMPLES);
        else
            n_eff = n_wide[AGE_W-1:0];
    end

    assign half    = n_eff >> 1;
    assign res_eff = (res_cfg_reg == '0) ? RES_W'(1) : res_cfg_reg;
    assign need    = FILL_W'(n_eff) + FILL_W'(dual_reg);
    assign divisor = {1'b0, res_eff, 1'b0};
    assign numv    = {1'b0, m1_reg, 1'b0} + NUM_W'(res_eff);
    assign head_inc = (head_reg == HIST_AW'(HIST_DEPTH - 1)) ? '0 : head_reg + 1'b1;

    // ring position of the entry rd_age pulses back from the newest
    always_comb
    begin
        logic [HIST_AW:0] h_ext;
        logic [HIST_AW:0] a_ext;
        logic [HIST_AW:0] pos;
        h_ext = {1'b0, head_reg};
        a_ext = (HIST_AW + 1)'(rd_age);
        if (h_ext >= a_ext)
            pos = h_ext - a_ext;
        else
            pos = h_ext + (HIST_AW + 1)'(HIST_DEPTH) - a_ext;
        rd_addr = pos[HIST_AW-1:0];
    end

    // ---------------- history RAM ----------------
    assign wr_en = pulse.valid && pulse.ready;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[head_inc] <= '{gates: pulse.pulse_gates, period: pulse.pulse_period_us,
                               azim: pulse.pulse_azimuth};
        rd_data_reg <= mem[rd_addr];
    end

    assign pdiff = (rd_data_reg.period > p0_reg) ? rd_data_reg.period - p0_reg
                                                 : p0_reg - rd_data_reg.period;
    assign mismatch = pend_reg && ((rd_data_reg.gates != g0_reg) ||
                                   (pdiff > PERIOD_W'(PERIOD_TOL_US)));
    assign trial = {rem_reg[DIV_W-2:0], num_reg[NUM_W-1]};

    // ---------------- beam decision ----------------
    always_comb
    begin
        logic [PCMP_W-1:0] psb_w;
        logic [PCMP_W-1:0] n_w;
        logic [PCMP_W-1:0] to_w;
        logic [T_W-1:0]    m1_w;
        logic [T_W-1:0]    m2_w;
        logic [T_W-1:0]    res_w;
        psb_w = PCMP_W'(psb_reg);
        n_w   = PCMP_W'(n_eff);
        to_w  = PCMP_W'({n_eff, {TIMEOUT_SHIFT{1'b0}}});
        m1_w  = T_W'(m1_reg);
        m2_w  = T_W'(m2_reg);
        res_w = T_W'(res_eff);
        res_cause = CAUSE_NONE;
        res_az    = '0;
        if (!fail_reg)
        begin
            if (!index_reg)
            begin
                if (psb_w >= n_w)
                begin
                    res_cause = CAUSE_COUNT;
                    res_az    = (m1_reg >= AZIM_W'(FULL_CIRCLE)) ?
                                m1_reg - AZIM_W'(FULL_CIRCLE) : m1_reg;
                end
            end
            else
            begin
                res_az = t_reg[AZIM_W-1:0];
                if (m1_w <= t_reg && m2_w >= t_reg)
                    res_cause = CAUSE_CW;
                else if (m1_w >= t_reg && m2_w <= t_reg)
                    res_cause = CAUSE_CCW;
                else if (t_reg == '0)
                begin
                    if (m1_w + res_w > T_W'(FULL_CIRCLE) && m2_w < res_w)
                        res_cause = CAUSE_CW_WRAP;
                    else if (m2_w + res_w > T_W'(FULL_CIRCLE) && m1_w < res_w)
                        res_cause = CAUSE_CCW_WRAP;
                end
                else if (psb_w > to_w)
                    res_cause = CAUSE_TIMEOUT;
            end
        end
        if (res_cause == CAUSE_NONE)
            res_az = '0;
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            fill_reg      <= '0;
            psb_reg       <= '0;
            age_reg       <= '0;
            pend_reg      <= 1'b0;
            fail_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            psb_reg       <= psb_next;
            age_reg       <= age_next;
            pend_reg      <= pend_next;
            fail_reg      <= fail_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        g0_reg        <= g0_next;
        p0_reg        <= p0_next;
        m1_reg        <= m1_next;
        m2_reg        <= m2_next;
        num_reg       <= num_next;
        rem_reg       <= rem_next;
        t_reg         <= t_next;
        out_beam_reg  <= out_beam_next;
        out_az_reg    <= out_az_next;
        out_cause_reg <= out_cause_next;
    end

    always_comb
    begin
        logic [NUM_W-1:0] diff;
        logic [T_W-1:0]   t_raw;
        state_next     = state_reg;
        head_next      = head_reg;
        fill_next      = fill_reg;
        psb_next       = psb_reg;
        age_next       = age_reg;
        pend_next      = pend_reg;
        fail_next      = fail_reg;
        cnt_next       = cnt_reg;
        g0_next        = g0_reg;
        p0_next        = p0_reg;
        m1_next        = m1_reg;
        m2_next        = m2_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        t_next         = t_reg;
        out_valid_next = out_valid_reg && !beam.ready;
        out_beam_next  = out_beam_reg;
        out_az_next    = out_az_reg;
        out_cause_next = out_cause_reg;
        rd_age         = age_reg;
        load_out       = 1'b0;
        diff           = numv - NUM_W'(rem_reg);
        t_raw          = diff[NUM_W-1:1];

        case (state_reg)
            ST_IDLE:
            begin
                if (pulse.valid)
                begin
                    head_next = head_inc;
                    if (fill_reg < FILL_W'(HIST_DEPTH))
                        fill_next = fill_reg + 1'b1;
                    if (psb_reg != COUNT_W'(COUNT_MAX))
                        psb_next = psb_reg + 1'b1;
                    g0_next    = pulse.pulse_gates;
                    p0_next    = pulse.pulse_period_us;
                    fail_next  = 1'b0;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                age_next  = AGE_W'(1);
                pend_next = 1'b0;
                if (fill_reg < need)
                begin
                    fail_next  = 1'b1;
                    state_next = ST_RESULT;
                end
                else
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (mismatch)
                begin
                    fail_next  = 1'b1;
                    pend_next  = 1'b0;
                    state_next = ST_RESULT;
                end
                else if (age_reg < n_eff)
                begin
                    age_next  = age_reg + 1'b1;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = ST_MID1;
                end
            end
            ST_MID1:
            begin
                rd_age     = half;
                state_next = ST_MID2;
            end
            ST_MID2:
            begin
                rd_age     = half - 1'b1;
                m1_next    = rd_data_reg.azim;
                state_next = ST_MIDCAP;
            end
            ST_MIDCAP:
            begin
                m2_next  = rd_data_reg.azim;
                num_next = numv;
                rem_next = '0;
                cnt_next = DCNT_W'(NUM_W);
                state_next = index_reg ? ST_DIV : ST_RESULT;
            end
            ST_DIV:
            begin
                rem_next = (trial >= divisor) ? trial - divisor : trial;
                num_next = {num_reg[NUM_W-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == DCNT_W'(1))
                    state_next = ST_TGT;
            end
            ST_TGT:
            begin
                t_next = (t_raw >= T_W'(FULL_CIRCLE)) ? t_raw - T_W'(FULL_CIRCLE) : t_raw;
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || beam.ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    out_beam_next  = (res_cause != CAUSE_NONE);
                    out_az_next    = res_az;
                    out_cause_next = res_cause;
                    if (res_cause != CAUSE_NONE)
                        psb_next = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign pulse.ready       = (state_reg == ST_IDLE);
    assign beam.valid        = out_valid_reg;
    assign beam.beam_ready   = out_beam_reg;
    assign beam.beam_azimuth = out_az_reg;
    assign beam.beam_cause   = out_cause_reg;

    // ---------------- assertions ----------------
    `ASSERT_NEXT(a_accept_check, wr_en, state_reg == ST_CHECK, "accepted beat did not start check")
    `ASSERT_NEXT(a_beam_clears, load_out && out_beam_next, psb_reg == '0, "count not cleared")
    `ASSERT_IMP(a_empty_beat, out_valid_reg && !out_beam_reg, {out_az_reg, out_cause_reg} == '0, "bad empty beat")
    `ASSERT_IMP(a_head_range, 1'b1, head_reg < HIST_AW'(HIST_DEPTH), "head out of range")
    `ASSERT_IMP(a_fill_range, 1'b1, fill_reg <= FILL_W'(HIST_DEPTH), "fill out of range")
    `ASSERT_IMP(a_scan_age, state_reg == ST_SCAN, age_reg <= n_eff && age_reg != '0, "bad scan age")

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import rbai_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 10;
    localparam int MAX_WAIT       = 19;
    localparam int HOLD_CYCLES    = 2500;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 300;

    typedef struct packed {
        logic   ready;
        azim_t  azimuth;
        cause_t cause;
    } beam_rec_t;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_PULSE,
        ROW_KNOWN
    } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        cfg_idx_t    idx;
        int unsigned value;
        gates_t      gates;
        period_t     period;
        azim_t       azim;
        beam_rec_t   beam;
    } dir_row_t;

    typedef struct {
        int unsigned n;
        int unsigned dual;
        int unsigned index_az;
        int unsigned res;
        int unsigned items;
        bit          pressure;
    } phase_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    rbai_pulse_if pulse_ch ();
    rbai_beam_if  beam_ch ();

    radar_beam_azimuth_indexer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pulse     (pulse_ch),
        .beam      (beam_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    gates_t      hist_g [HIST_DEPTH];
    period_t     hist_p [HIST_DEPTH];
    azim_t       hist_a [HIST_DEPTH];
    int unsigned hist_count  = 0;
    int unsigned hist_head   = 0;
    int unsigned pulse_count = 0;

    int unsigned reg_n     = 64;
    int unsigned reg_dual  = 0;
    int unsigned reg_index = 1;
    int unsigned reg_res   = 100;

    beam_rec_t   expected_beams [$];
    int unsigned mismatches   = 0;
    int unsigned quiet_cycles = 0;
    bit          rx_hold_req  = 1'b0;
    bit          tx_burst     = 1'b0;
    bit          rx_burst     = 1'b0;
    bit          cfg_open     = 1'b0;

    // current dwell of the synthetic antenna sweep
    int unsigned dw_left   = 0;
    int unsigned dw_gates  = 0;
    int unsigned dw_period = 0;
    int          dw_az     = 0;
    int          dw_step   = 0;

    function automatic int unsigned eff_n();
        if (reg_n < 2)
        begin
            return 2;
        end
        if (reg_n > MAX_SAMPLES)
        begin
            return MAX_SAMPLES;
        end
        return reg_n;
    endfunction

    function automatic int unsigned eff_res();
        return (reg_res == 0) ? 1 : reg_res;
    endfunction

    function automatic int unsigned hist_slot(int unsigned age);
        return (hist_head + HIST_DEPTH - age) % HIST_DEPTH;
    endfunction

    function automatic beam_rec_t predict_beam(gates_t g, period_t p, azim_t a);
        int unsigned n;
        int unsigned res;
        int unsigned m1;
        int unsigned m2;
        int unsigned tgt;
        int unsigned p0;
        int unsigned pi;
        int unsigned diff;
        int unsigned s;
        bit          match;
        beam_rec_t   r;
        r = '0;
        tgt = 0;
        hist_head = (hist_head + 1) % HIST_DEPTH;
        hist_g[hist_head] = g;
        hist_p[hist_head] = p;
        hist_a[hist_head] = a;
        if (hist_count < HIST_DEPTH)
        begin
            hist_count++;
        end
        if (pulse_count < COUNT_MAX)
        begin
            pulse_count++;
        end
        n = eff_n();
        res = eff_res();
        p0 = p;
        match = (hist_count >= n + reg_dual);
        for (int unsigned i = 1; i < n && match; i++)
        begin
            s = hist_slot(i);
            pi = hist_p[s];
            diff = (pi > p0) ? pi - p0 : p0 - pi;
            if (hist_g[s] != g || diff > PERIOD_TOL_US)
            begin
                match = 1'b0;
            end
        end
        if (match)
        begin
            m1 = hist_a[hist_slot(n / 2)];
            m2 = hist_a[hist_slot(n / 2 - 1)];
            if (reg_index == 0)
            begin
                tgt = (m1 >= FULL_CIRCLE) ? m1 - FULL_CIRCLE : m1;
                if (pulse_count >= n)
                begin
                    r.cause = CAUSE_COUNT;
                end
            end
            else
            begin
                tgt = ((2 * m1 + res) / (2 * res)) * res;
                if (tgt >= FULL_CIRCLE)
                begin
                    tgt -= FULL_CIRCLE;
                end
                if (m1 <= tgt && m2 >= tgt)
                begin
                    r.cause = CAUSE_CW;
                end
                else if (m1 >= tgt && m2 <= tgt)
                begin
                    r.cause = CAUSE_CCW;
                end
                else if (tgt == 0)
                begin
                    if (m1 + res > FULL_CIRCLE && m2 < res)
                    begin
                        r.cause = CAUSE_CW_WRAP;
                    end
                    else if (m2 + res > FULL_CIRCLE && m1 < res)
                    begin
                        r.cause = CAUSE_CCW_WRAP;
                    end
                end
                else if (pulse_count > (n << TIMEOUT_SHIFT))
                begin
                    r.cause = CAUSE_TIMEOUT;
                end
            end
        end
        if (r.cause != CAUSE_NONE)
        begin
            r.ready = 1'b1;
            r.azimuth = azim_t'(tgt);
            pulse_count = 0;
        end
        return r;
    endfunction

    function automatic dir_row_t cfg_row(cfg_idx_t idx, int unsigned value);
        dir_row_t r;
        r.kind = ROW_CFG;
        r.idx = idx;
        r.value = value;
        return r;
    endfunction

    function automatic dir_row_t pulse_row(gates_t g, period_t p, azim_t a);
        dir_row_t r;
        r.kind = ROW_PULSE;
        r.gates = g;
        r.period = p;
        r.azim = a;
        r.beam = '0;
        return r;
    endfunction

    function automatic dir_row_t known_row(gates_t g, period_t p, azim_t a,
                                           azim_t az, cause_t cause);
        dir_row_t r;
        r = pulse_row(g, p, a);
        r.kind = ROW_KNOWN;
        r.beam.ready = (cause != CAUSE_NONE);
        r.beam.azimuth = az;
        r.beam.cause = cause;
        return r;
    endfunction

    task automatic cfg_write(cfg_idx_t idx, int unsigned value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_W'(value);
        @(posedge clk);
        case (idx)
            CFG_BEAM_LEN:  reg_n = value % (1 << N_W);
            CFG_DUAL_POL:  reg_dual = value % 2;
            CFG_INDEX_AZ:  reg_index = value % 2;
            CFG_AZ_RES:    reg_res = value % (1 << RES_W);
            default:       ;
        endcase
        cfg_open = 1'b1;
    endtask

    task automatic cfg_close();
        if (cfg_open)
        begin
            cfg_we <= 1'b0;
            cfg_open = 1'b0;
        end
    endtask

    task automatic wait_idle();
        pulse_ch.valid <= 1'b0;
        while (expected_beams.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_pulse(gates_t g, period_t p, azim_t a, bit known,
                              beam_rec_t known_beam);
        int unsigned gap;
        beam_rec_t   b;
        cfg_close();
        if ($urandom_range(0, 49) == 0)
        begin
            tx_burst = !tx_burst;
        end
        gap = tx_burst ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap != 0)
        begin
            pulse_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pulse_ch.valid <= 1'b1;
        pulse_ch.pulse_gates <= g;
        pulse_ch.pulse_period_us <= p;
        pulse_ch.pulse_azimuth <= a;
        @(posedge clk);
        while (!pulse_ch.ready)
        begin
            @(posedge clk);
        end
        b = predict_beam(g, p, a);
        expected_beams.insert(expected_beams.size(), known ? known_beam : b);
    endtask

    // mostly clean dwells (same gates, periods within tolerance, steady sweep),
    // with occasional noise and broken pulses
    task automatic next_pulse(output gates_t g, output period_t p, output azim_t a);
        int unsigned n;
        int unsigned res;
        int unsigned mag;
        int unsigned roll;
        n = eff_n();
        res = eff_res();
        if (dw_left == 0)
        begin
            roll = $urandom_range(0, 9);
            dw_gates = (roll == 0) ? 0 : (roll == 1) ? 4095 : $urandom_range(0, 4095);
            dw_period = $urandom_range(0, 65535 - PERIOD_TOL_US);
            dw_az = $urandom_range(0, FULL_CIRCLE - 1);
            if (n <= 16 && $urandom_range(0, 5) == 0)
            begin
                dw_step = 0;
                dw_left = (n << TIMEOUT_SHIFT) + $urandom_range(1, 40);
            end
            else
            begin
                mag = $urandom_range(1, 2 * res / n + 20);
                dw_step = $urandom_range(0, 1) ? int'(mag) : -int'(mag);
                dw_left = n * $urandom_range(1, 3) + $urandom_range(0, 40);
            end
        end
        if ($urandom_range(0, (n > 32) ? 8 * n : 12) == 0)
        begin
            if ($urandom_range(0, 1) == 1)
            begin
                g = gates_t'($urandom);
                p = period_t'($urandom);
                a = azim_t'($urandom);
            end
            else
            begin
                g = gates_t'(dw_gates);
                p = period_t'(dw_period + $urandom_range(PERIOD_TOL_US + 1, 3000));
                a = azim_t'(dw_az);
            end
        end
        else
        begin
            g = gates_t'(dw_gates);
            p = period_t'(dw_period + $urandom_range(0, PERIOD_TOL_US));
            a = azim_t'(dw_az);
            dw_az = (dw_az + FULL_CIRCLE + dw_step) % FULL_CIRCLE;
            dw_left--;
        end
    endtask

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    always @(posedge clk)
    begin : beam_check
        beam_rec_t want;
        if (rst_n && beam_ch.valid && beam_ch.ready)
        begin
            if (expected_beams.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, actual %0d/%0d/%0d", $time,
                         beam_ch.beam_ready, beam_ch.beam_azimuth, beam_ch.beam_cause);
                mismatches++;
            end
            else
            begin
                want = expected_beams.pop_front();
                check_field("beam_ready", 16'(want.ready), 16'(beam_ch.beam_ready));
                check_field("beam_azimuth", want.azimuth, beam_ch.beam_azimuth);
                check_field("beam_cause", 16'(want.cause), 16'(beam_ch.beam_cause));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (pulse_ch.valid && pulse_ch.ready) || (beam_ch.valid && beam_ch.ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin : beam_sink
        int unsigned stall;
        beam_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                beam_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if ($urandom_range(0, 49) == 0)
            begin
                rx_burst = !rx_burst;
            end
            stall = rx_burst ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall != 0)
            begin
                beam_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            beam_ch.ready <= 1'b1;
            @(posedge clk);
            while (!beam_ch.valid)
            begin
                @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        dir_row_t directed [$];
        phase_t   phases [$];
        gates_t   g;
        period_t  p;
        azim_t    a;
        bit       after_pulse;

        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_BEAM_LEN;
        cfg_wdata <= '0;
        pulse_ch.valid <= 1'b0;
        pulse_ch.pulse_gates <= '0;
        pulse_ch.pulse_period_us <= '0;
        pulse_ch.pulse_azimuth <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed = '{
            known_row(12'd4095, 16'd65535, 16'd65535, 16'd0, CAUSE_NONE),
            cfg_row(CFG_BEAM_LEN, 0),
            cfg_row(CFG_DUAL_POL, 1),
            cfg_row(CFG_INDEX_AZ, 0),
            // dual pol needs a third pulse
            known_row(12'd4095, 16'd65535, 16'd35999, 16'd0, CAUSE_NONE),
            known_row(12'd4095, 16'd65535, 16'd0, 16'd35999, CAUSE_COUNT),
            known_row(12'd0, 16'd0, 16'd0, 16'd0, CAUSE_NONE),
            cfg_row(CFG_DUAL_POL, 0),
            cfg_row(CFG_INDEX_AZ, 1),
            cfg_row(CFG_BEAM_LEN, 1),
            known_row(12'd5, 16'd1000, 16'd190, 16'd0, CAUSE_NONE),
            known_row(12'd5, 16'd1000, 16'd210, 16'd200, CAUSE_CW),
            known_row(12'd5, 16'd1000, 16'd190, 16'd200, CAUSE_CCW),
            pulse_row(12'd5, 16'd2000, 16'd35990),
            known_row(12'd5, 16'd2000, 16'd10, 16'd0, CAUSE_CW_WRAP),
            known_row(12'd5, 16'd2000, 16'd35990, 16'd0, CAUSE_CCW_WRAP),
            known_row(12'd5, 16'd3001, 16'd35990, 16'd0, CAUSE_NONE),
            pulse_row(12'd5, 16'd3001, 16'd150),
            pulse_row(12'd5, 16'd2001, 16'd150),
            cfg_row(CFG_AZ_RES, 0),
            pulse_row(12'd5, 16'd2001, 16'd151),
            cfg_row(CFG_AZ_RES, 3600),
            pulse_row(12'd5, 16'd2001, 16'd1900),
            pulse_row(12'd5, 16'd2001, 16'd65535),
            pulse_row(12'd5, 16'd2001, 16'd40000),
            cfg_row(CFG_AZ_RES, 100),
            cfg_row(CFG_INDEX_AZ, 0),
            pulse_row(12'd7, 16'd500, 16'd100),
            pulse_row(12'd7, 16'd500, 16'd200),
            pulse_row(12'd7, 16'd500, 16'd300),
            pulse_row(12'd7, 16'd500, 16'd40000),
            pulse_row(12'd7, 16'd500, 16'd50),
            pulse_row(12'd7, 16'd500, 16'd60)
        };

        after_pulse = 1'b0;
        foreach (directed[i])
        begin
            if (directed[i].kind == ROW_CFG)
            begin
                if (after_pulse)
                begin
                    wait_idle();
                end
                after_pulse = 1'b0;
                cfg_write(directed[i].idx, directed[i].value);
            end
            else
            begin
                send_pulse(directed[i].gates, directed[i].period, directed[i].azim,
                           directed[i].kind == ROW_KNOWN, directed[i].beam);
                after_pulse = 1'b1;
            end
        end
        wait_idle();

        phases = '{
            '{2, 0, 1, 100, 250, 1'b0},
            '{4, 0, 1, 1, 200, 1'b0},
            '{8, 1, 1, 3600, 200, 1'b0},
            '{3, 0, 0, 4095, 200, 1'b0},
            '{16, 1, 1, 250, 200, 1'b0},
            '{300, 1, 1, 100, 300, 1'b0},
            '{1, 0, 0, 0, 200, 1'b0},
            '{5, 0, 1, 7, 300, 1'b1}
        };

        foreach (phases[k])
        begin
            cfg_write(CFG_BEAM_LEN, phases[k].n);
            cfg_write(CFG_DUAL_POL, phases[k].dual);
            cfg_write(CFG_INDEX_AZ, phases[k].index_az);
            cfg_write(CFG_AZ_RES, phases[k].res);
            dw_left = 0;
            if (phases[k].pressure)
            begin
                rx_hold_req = 1'b1;
            end
            repeat (phases[k].items)
            begin
                next_pulse(g, p, a);
                send_pulse(g, p, a, 1'b0, '0);
            end
            wait_idle();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
